### rtl/core/bsc_pkg.sv
package bsc_pkg;

    // word queue between front and back
    localparam int QDEPTH = 4;

    // divider: quotient bits retired per pipeline stage
    localparam int QBITS     = 2;
    localparam int DIV_W     = 64;
    localparam int DIV_STEPS = DIV_W / QBITS;

    localparam logic [20:0]        P_BASE  = 21'd1048576;
    localparam logic signed [24:0] T_OFS   = 25'sd128000;
    localparam logic [11:0]        P_SCALE = 12'd3125;
    localparam logic [63:0]        DEN_BIAS = 64'h0000_8000_0000_0000;  // 2^47
    localparam int                 DEN_SHIFT = 33;
    localparam int                 P4_SHIFT  = 35;

    typedef enum logic [1:0] {
        CFG_TEMP  = 2'd0,
        CFG_PLOW  = 2'd1,
        CFG_PMID  = 2'd2,
        CFG_PHIGH = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [15:0]        t1;
        logic signed [15:0] t2;
        logic signed [15:0] t3;
        logic [15:0]        p1;
        logic signed [15:0] p2;
        logic signed [15:0] p3;
        logic signed [15:0] p4;
        logic signed [15:0] p5;
        logic signed [15:0] p6;
        logic signed [15:0] p7;
        logic signed [15:0] p8;
        logic signed [15:0] p9;
    } t_cal;

    // one word handed from front to back
    typedef struct packed {
        logic signed [23:0] fine;
        logic signed [18:0] centi;
        logic [63:0]        num;
        logic signed [30:0] den;
    } t_job;

    typedef struct packed {
        logic push;
        logic space;
    } t_qctl;

endpackage

### rtl/core/bsc_in_if.sv
interface bsc_in_if;
    logic        valid;
    logic        ready;
    logic [19:0] raw_temperature;
    logic [19:0] raw_pressure;

    modport source (output valid, raw_temperature, raw_pressure, input ready);
    modport sink   (input valid, raw_temperature, raw_pressure, output ready);
endinterface

### rtl/core/bsc_out_if.sv
interface bsc_out_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] fine_temperature;
    logic signed [18:0] temperature_centi;
    logic [31:0]        pressure_q24_8;
    logic               divide_fault;

    modport source (output valid, fine_temperature, temperature_centi, pressure_q24_8,
                    divide_fault, input ready);
    modport sink   (input valid, fine_temperature, temperature_centi, pressure_q24_8,
                    divide_fault, output ready);
endinterface

### rtl/core/baro_sensor_compensation.sv
// Barometric compensation engine: each input word carries a raw 20-bit
// temperature and a raw 20-bit pressure reading; each output word returns the
// fine temperature, the temperature in 0.01 degC and the pressure in Pa as
// unsigned Q24.8 (saturated), plus a fault flag that is set, with pressure 0,
// when the pressure divisor comes out zero. Calibration (T1..T3, P1..P9) is
// loaded through the write port at indexes 0..3 and must only change while
// no word is in flight. Throughput is one word per clock while neither
// handshake stalls; a word passes 7 front stages, the 4-word queue and 38
// back stages, most of them the 64-bit divider retiring 2 quotient bits
// per stage. Both handshakes stall independently: the front keeps accepting
// until the queue fills, the back keeps draining while the output is taken.
module baro_sensor_compensation #(
    parameter int QDEPTH = bsc_pkg::QDEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    bsc_in_if.sink      i_in,
    bsc_out_if.source   o_out
);

    bsc_pkg::t_cal  r_cal;
    bsc_pkg::t_job  f_job, q_job;
    bsc_pkg::t_qctl qctl;
    logic           q_valid, b_pop;

    // calibration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal <= '0;
        end else if (i_cfg_we) begin
            unique case (bsc_pkg::t_cfg_idx'(i_cfg_idx))
                bsc_pkg::CFG_TEMP: begin
                    r_cal.t1 <= i_cfg_data[15:0];
                    r_cal.t2 <= i_cfg_data[31:16];
                    r_cal.t3 <= i_cfg_data[47:32];
                end
                bsc_pkg::CFG_PLOW: begin
                    r_cal.p1 <= i_cfg_data[15:0];
                    r_cal.p2 <= i_cfg_data[31:16];
                    r_cal.p3 <= i_cfg_data[47:32];
                    r_cal.p4 <= i_cfg_data[63:48];
                end
                bsc_pkg::CFG_PMID: begin
                    r_cal.p5 <= i_cfg_data[15:0];
                    r_cal.p6 <= i_cfg_data[31:16];
                    r_cal.p7 <= i_cfg_data[47:32];
                    r_cal.p8 <= i_cfg_data[63:48];
                end
                bsc_pkg::CFG_PHIGH: begin
                    r_cal.p9 <= i_cfg_data[15:0];
                end
                default: begin
                end
            endcase
        end
    end

    // front: temperature math, divisor and dividend
    bsc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cal   (r_cal),
        .in_ch   (i_in),
        .i_space (qctl.space),
        .o_push  (qctl.push),
        .o_job   (f_job)
    );

    bsc_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (qctl),
        .i_job   (f_job),
        .o_space (qctl.space),
        .o_valid (q_valid),
        .i_pop   (b_pop),
        .o_job   (q_job)
    );

    // back: pipelined divide and pressure correction
    bsc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cal   (r_cal),
        .i_valid (q_valid),
        .i_job   (q_job),
        .o_pop   (b_pop),
        .out_ch  (o_out)
    );

endmodule

### rtl/core/bsc_front.sv
module bsc_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bsc_pkg::t_cal   i_cal,
    bsc_in_if.sink          in_ch,
    input  logic            i_space,
    output logic            o_push,
    output bsc_pkg::t_job   o_job
);

    localparam int NSTG = 7;

    logic            en;
    logic [NSTG-1:0] r_v;

    // stage regs
    logic signed [33:0] r_pt;
    logic [20:0]        r_ee;
    logic signed [22:0] r_ta;
    logic signed [37:0] r_tbp;
    logic signed [23:0] r_fine3, r_fine4, r_fine5, r_fine6, r_fine7;
    logic signed [18:0] r_cen3, r_cen4, r_cen5, r_cen6, r_cen7;
    logic [19:0]        r_ap1, r_ap2, r_ap3, r_ap4, r_ap5, r_ap6;
    logic signed [49:0] r_sq;
    logic signed [40:0] r_vp5, r_vp2, r_vp5b, r_vp2b;
    logic signed [63:0] r_a6, r_a3;
    logic [63:0]        r_v2, r_v1b, r_num, r_denr;

    // comb
    logic signed [17:0] d;
    logic signed [16:0] e;
    logic signed [33:0] pt, ee_s;
    logic signed [37:0] tbp, tbs;
    logic signed [33:0] tas;
    logic signed [23:0] fine;
    logic signed [26:0] f27, c27, cs;
    logic signed [24:0] v1;
    logic signed [49:0] sq;
    logic signed [40:0] vp5, vp2;
    logic signed [65:0] a6w, a3w;
    logic signed [63:0] a3s;
    logic [63:0]        v2, v1b, pp, num, denr;

    assign en          = i_space;
    assign in_ch.ready = en;
    assign o_push      = r_v[NSTG-1] && en;

    always_comb begin
        d    = signed'({1'b0, in_ch.raw_temperature[19:3]}) - signed'({1'b0, i_cal.t1, 1'b0});
        e    = signed'({1'b0, in_ch.raw_temperature[19:4]}) - signed'({1'b0, i_cal.t1});
        pt   = d * i_cal.t2;
        ee_s = e * e;

        tas  = r_pt >>> 11;
        tbp  = signed'({1'b0, r_ee}) * i_cal.t3;

        tbs  = r_tbp >>> 14;
        fine = {r_ta[22], r_ta} + tbs[23:0];
        f27  = {{3{fine[23]}}, fine};
        c27  = (f27 <<< 2) + f27 + 27'sd128;
        cs   = c27 >>> 8;

        v1   = {r_fine3[23], r_fine3} - bsc_pkg::T_OFS;
        sq   = v1 * v1;
        vp5  = v1 * i_cal.p5;
        vp2  = v1 * i_cal.p2;

        a6w  = r_sq * i_cal.p6;
        a3w  = r_sq * i_cal.p3;

        a3s  = r_a3 >>> 8;
        v2   = r_a6 + ({{23{r_vp5b[40]}}, r_vp5b} << 17)
             + ({{48{i_cal.p4[15]}}, i_cal.p4} << bsc_pkg::P4_SHIFT);
        v1b  = a3s + ({{23{r_vp2b[40]}}, r_vp2b} << 12);

        pp   = {43'b0, bsc_pkg::P_BASE - {1'b0, r_ap6}} << 31;
        num  = (pp - r_v2) * {52'b0, bsc_pkg::P_SCALE};
        denr = (bsc_pkg::DEN_BIAS + r_v1b) * {48'b0, i_cal.p1};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[NSTG-2:0], in_ch.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pt    <= pt;
            r_ee    <= ee_s[32:12];
            r_ap1   <= in_ch.raw_pressure;
            r_ta    <= tas[22:0];
            r_tbp   <= tbp;
            r_ap2   <= r_ap1;
            r_fine3 <= fine;
            r_cen3  <= cs[18:0];
            r_ap3   <= r_ap2;
            r_sq    <= sq;
            r_vp5   <= vp5;
            r_vp2   <= vp2;
            r_fine4 <= r_fine3;
            r_cen4  <= r_cen3;
            r_ap4   <= r_ap3;
            r_a6    <= a6w[63:0];
            r_a3    <= a3w[63:0];
            r_vp5b  <= r_vp5;
            r_vp2b  <= r_vp2;
            r_fine5 <= r_fine4;
            r_cen5  <= r_cen4;
            r_ap5   <= r_ap4;
            r_v2    <= v2;
            r_v1b   <= v1b;
            r_fine6 <= r_fine5;
            r_cen6  <= r_cen5;
            r_ap6   <= r_ap5;
            r_num   <= num;
            r_denr  <= denr;
            r_fine7 <= r_fine6;
            r_cen7  <= r_cen6;
        end
    end

    assign o_job.fine  = r_fine7;
    assign o_job.centi = r_cen7;
    assign o_job.num   = r_num;
    assign o_job.den   = r_denr[63:bsc_pkg::DEN_SHIFT];

endmodule

### rtl/core/bsc_queue.sv
module bsc_queue #(
    parameter int DEPTH = bsc_pkg::QDEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  bsc_pkg::t_qctl i_ctl,
    input  bsc_pkg::t_job  i_job,
    output logic           o_space,
    output logic           o_valid,
    input  logic           i_pop,
    output bsc_pkg::t_job  o_job
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    bsc_pkg::t_job r_mem [DEPTH];
    logic [IW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;
    logic          pop;

    assign o_space = (r_cnt != CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign pop     = i_pop && o_valid;
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_ctl.push) begin
                r_wp <= (r_wp == IW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= (r_rp == IW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_ctl.push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !i_ctl.push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH))
        else $error("queue count overflow");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.push |-> i_ctl.space)
        else $error("push into full queue");
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> (r_wp == r_rp))
        else $error("pointers disagree with empty count");

endmodule

### rtl/core/bsc_back.sv
module bsc_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  bsc_pkg::t_cal i_cal,
    input  logic          i_valid,
    input  bsc_pkg::t_job i_job,
    output logic          o_pop,
    bsc_out_if.source     out_ch
);

    localparam int NS  = bsc_pkg::DIV_STEPS;
    localparam int NV  = NS + 6;
    localparam int QB  = bsc_pkg::QBITS;
    localparam int DW  = bsc_pkg::DIV_W;

    logic          en;
    logic [NV-1:0] r_v;

    // divider pipeline, index 0 is the operand stage
    logic [DW-1:0]      r_dq   [NS+1];
    logic [30:0]        r_dr   [NS+1];
    logic [30:0]        r_dd   [NS+1];
    logic               r_neg  [NS+1];
    logic               r_flt  [NS+1];
    logic signed [23:0] r_fine [NS+1];
    logic signed [18:0] r_cen  [NS+1];

    logic [DW-1:0]      nq [NS];
    logic [30:0]        nr [NS];

    // post-divide stages
    logic signed [63:0] r_p0, r_p1, r_p2, r_a1, r_m1, r_q21, r_q22, r_sum;
    logic [63:0]        r_ll;
    logic [31:0]        r_hl, r_lh;
    logic               r_f0, r_f1, r_f2, r_f3;
    logic signed [23:0] r_fi0, r_fi1, r_fi2, r_fi3;
    logic signed [18:0] r_ce0, r_ce1, r_ce2, r_ce3;

    logic signed [23:0] r_ofine;
    logic signed [18:0] r_ocen;
    logic [31:0]        r_opr;
    logic               r_oflt;

    logic [63:0]        ma;
    logic [30:0]        mb;
    logic signed [63:0] a, m2, q1s, q2s, fin;
    logic signed [79:0] m1w, q2w;
    logic [63:0]        ll;
    logic [31:0]        hl, lh;
    logic [31:0]        pr;

    assign en    = !r_v[NV-1] || out_ch.ready;
    assign o_pop = i_valid && en;

    always_comb begin
        ma  = i_job.num[63] ? (64'd0 - i_job.num) : i_job.num;
        mb  = i_job.den[30] ? (31'd0 - i_job.den) : i_job.den;

        a   = r_p0 >>> 13;
        m1w = a * i_cal.p9;
        q2w = r_p0 * i_cal.p8;

        ll  = {32'b0, r_m1[31:0]} * {32'b0, r_a1[31:0]};
        hl  = r_m1[63:32] * r_a1[31:0];
        lh  = r_m1[31:0] * r_a1[63:32];

        m2  = r_ll + {r_hl + r_lh, 32'b0};
        q1s = m2 >>> 25;
        q2s = r_q22 >>> 19;

        fin = (r_sum >>> 8) + signed'({{48{i_cal.p7[15]}}, i_cal.p7} << 4);
        if (fin[63]) begin
            pr = '0;
        end else if (fin[62:32] != '0) begin
            pr = '1;
        end else begin
            pr = fin[31:0];
        end
    end

    // restoring divide, QB quotient bits per stage
    for (genvar k = 0; k < NS; k++) begin : g_div
        always_comb begin
            logic [31:0]   t;
            logic [30:0]   rem;
            logic [DW-1:0] q;
            rem = r_dr[k];
            q   = r_dq[k];
            for (int j = 0; j < QB; j++) begin
                t = {rem, q[DW-1]};
                q = {q[DW-2:0], 1'b0};
                if (t >= {1'b0, r_dd[k]}) begin
                    t    = t - {1'b0, r_dd[k]};
                    q[0] = 1'b1;
                end
                rem = t[30:0];
            end
            nq[k] = q;
            nr[k] = rem;
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dq[k+1]   <= nq[k];
                r_dr[k+1]   <= nr[k];
                r_dd[k+1]   <= r_dd[k];
                r_neg[k+1]  <= r_neg[k];
                r_flt[k+1]  <= r_flt[k];
                r_fine[k+1] <= r_fine[k];
                r_cen[k+1]  <= r_cen[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[NV-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dq[0]   <= ma;
            r_dr[0]   <= '0;
            r_dd[0]   <= mb;
            r_neg[0]  <= i_job.num[63] ^ i_job.den[30];
            r_flt[0]  <= (i_job.den == '0);
            r_fine[0] <= i_job.fine;
            r_cen[0]  <= i_job.centi;

            r_p0  <= r_neg[NS] ? signed'(64'd0 - r_dq[NS]) : signed'(r_dq[NS]);
            r_f0  <= r_flt[NS];
            r_fi0 <= r_fine[NS];
            r_ce0 <= r_cen[NS];

            r_a1  <= a;
            r_m1  <= m1w[63:0];
            r_q21 <= q2w[63:0];
            r_p1  <= r_p0;
            r_f1  <= r_f0;
            r_fi1 <= r_fi0;
            r_ce1 <= r_ce0;

            r_ll  <= ll;
            r_hl  <= hl;
            r_lh  <= lh;
            r_q22 <= r_q21;
            r_p2  <= r_p1;
            r_f2  <= r_f1;
            r_fi2 <= r_fi1;
            r_ce2 <= r_ce1;

            r_sum <= r_p2 + q1s + q2s;
            r_f3  <= r_f2;
            r_fi3 <= r_fi2;
            r_ce3 <= r_ce2;

            r_ofine <= r_fi3;
            r_ocen  <= r_ce3;
            r_opr   <= r_f3 ? '0 : pr;
            r_oflt  <= r_f3;
        end
    end

    assign out_ch.valid             = r_v[NV-1];
    assign out_ch.fine_temperature  = r_ofine;
    assign out_ch.temperature_centi = r_ocen;
    assign out_ch.pressure_q24_8    = r_opr;
    assign out_ch.divide_fault      = r_oflt;

    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_ch.valid && out_ch.divide_fault) |-> (out_ch.pressure_q24_8 == '0))
        else $error("fault word carries nonzero pressure");
    a_pop_en: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_v[0])
        else $error("popped word lost at divider entry");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[NV-1] && !out_ch.ready) |=> $stable(r_v))
        else $error("pipeline moved while output stalled");

endmodule
